// File: hdl/iso8601_timestamp_parser_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ISO8601_TIMESTAMP_PARSER_MACROS_SVH
`define ISO8601_TIMESTAMP_PARSER_MACROS_SVH

// Same-cycle implication under reset disable.
`define ISOTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("isots assertion failed");

// Next-cycle implication under reset disable.
`define ISOTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("isots assertion failed");

`endif

// File: hdl/isots_pkg.sv
// Shared types, constants and calendar functions of the timestamp parser.
package isots_pkg;

  localparam int FIELD_BITS_DEF  = 14;
  localparam int FRACTION_DIGITS = 3;
  localparam int NUM_PARTS       = 9;
  localparam int YEAR_MAX        = 9999;
  localparam int MS_MAX          = 999;
  localparam int MIN_PER_DAY     = 1440;
  localparam int MIN_PER_HOUR    = 60;
  localparam int LEAP_CYCLE      = 400;

  localparam logic [3:0] PH_YEAR   = 4'd0;
  localparam logic [3:0] PH_MONTH  = 4'd1;
  localparam logic [3:0] PH_DAY    = 4'd2;
  localparam logic [3:0] PH_HOUR   = 4'd3;
  localparam logic [3:0] PH_MINUTE = 4'd4;
  localparam logic [3:0] PH_SECOND = 4'd5;
  localparam logic [3:0] PH_FRAC   = 4'd6;
  localparam logic [3:0] PH_TZHOUR = 4'd7;
  localparam logic [3:0] PH_TZMIN  = 4'd8;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SYNTAX = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;
  localparam logic [1:0] ST_UTC    = 2'd3;

  localparam logic [4:0] MONTH_DAYS [13] = '{5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31,
                                             5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30,
                                             5'd31};

  typedef enum logic [1:0] {S_IDLE, S_END, S_CALC, S_WAIT} top_state_t;
  typedef enum logic [2:0] {C_IDLE, C_MOD, C_CHECK, C_OFF, C_T, C_STEP, C_DONE} cal_state_t;

  typedef struct packed {
    logic failed;
    logic ignore_rest;
    logic tz_negative;
  } parse_flags_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;
  } result_t;

  // rem is the year modulo 400
  function automatic logic leap_of(input logic [8:0] rem);
    logic century;
    century = (rem == 9'd100) || (rem == 9'd200) || (rem == 9'd300);
    return (rem[1:0] == 2'b00) && !century;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    if (m == 4'd2 && leap) return 5'd29;
    if (m >= 4'd1 && m <= 4'd12) return MONTH_DAYS[m];
    return 5'd0;
  endfunction

endpackage

// File: hdl/iso8601_timestamp_parser.sv
// Top level of the streaming ISO 8601 timestamp parser.
// Characters are taken one per cycle while the block is idle; each field is
// read strtol-style and range checked, and the timezone offset is removed to
// give UTC. On the last character the block stops taking input: the S_END
// state feeds the end of text when that character is not zero, then a
// calendar sequencer runs. A syntax error or a year outside 1..9999 goes
// straight to the result; otherwise the year is reduced modulo 400 by
// repeated subtraction, the date and time of day are range checked, and a
// good timestamp applies the offset and walks the day shift, the number of
// whole days the offset moves the date, one day per cycle through a single
// day-step unit. The calendar result waits in its state until the output
// register is free. The result sits in an output register so the next text
// can start while it waits to be taken.
module iso8601_timestamp_parser import isots_pkg::*; #(
  parameter int FIELD_BITS = FIELD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_char,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [13:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [9:0]  out_millisecond
);
  top_state_t   state_r, state_nxt;
  logic         accept, slot_free, emit;
  logic         feed_en, at_end, cal_start, cal_done;
  logic [7:0]   feed_c;
  parse_flags_t flags;
  logic signed [FIELD_BITS+7:0] parts [NUM_PARTS];
  result_t      res, out_r;
  logic         out_valid_r;

  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign emit      = (state_r == S_WAIT) && cal_done && slot_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_is_last) state_nxt = (in_text_char == 8'd0) ? S_CALC : S_END;
      end
      S_END:   state_nxt = S_CALC;
      S_CALC:  state_nxt = S_WAIT;
      S_WAIT:  if (emit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer: feed the character, or the implied end of text
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    feed_en   = accept || (state_r == S_END);
    feed_c    = (state_r == S_END) ? 8'd0 : in_text_char;
    at_end    = (state_r == S_END) || (in_text_char == 8'd0);
    cal_start = (state_r == S_CALC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // hold the result until it is taken
  always_ff @(posedge clk) begin
    if (emit) out_r <= res;
  end

  isots_parse #(.FIELD_BITS(FIELD_BITS)) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .feed_en (feed_en),
    .clr     (emit),
    .c       (feed_c),
    .at_end  (at_end),
    .flags   (flags),
    .parts   (parts)
  );

  isots_cal #(.FIELD_BITS(FIELD_BITS)) u_cal (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cal_start),
    .ack   (emit),
    .flags (flags),
    .parts (parts),
    .done  (cal_done),
    .res   (res)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_year        = out_r.year;
  assign out_month       = out_r.month;
  assign out_day         = out_r.day;
  assign out_hour        = out_r.hour;
  assign out_minute      = out_r.minute;
  assign out_second      = out_r.second;
  assign out_millisecond = out_r.millisecond;
endmodule

// File: hdl/isots_parse.sv
// Character parser: field accumulation, separators and part storage.
module isots_parse import isots_pkg::*; #(
  parameter int FIELD_BITS = FIELD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        feed_en,
  input  logic                        clr,
  input  logic [7:0]                  c,
  input  logic                        at_end,
  output parse_flags_t                flags,
  output logic signed [FIELD_BITS+7:0] parts [NUM_PARTS]
);
  localparam int PW = FIELD_BITS + 8;
  localparam logic [FIELD_BITS-1:0] MAG_MAX = {FIELD_BITS{1'b1}};

  logic [3:0]            phase_r, phase_nxt;
  logic [FIELD_BITS-1:0] accum_r, accum_nxt;
  logic                  neg_r, neg_nxt, sgn_r, sgn_nxt, seen_r, seen_nxt;
  logic [2:0]            chars_r, chars_nxt;
  logic                  tzneg_r, tzneg_nxt, failed_r, failed_nxt, ign_r, ign_nxt;
  logic signed [PW-1:0]  parts_r [NUM_PARTS];
  logic signed [PW-1:0]  parts_nxt [NUM_PARTS];
  logic [FIELD_BITS+3:0] prod;
  logic signed [PW-1:0]  v, vscaled;
  logic [2:0]            chars_inc;
  logic                  is_digit, is_sign;

  always_comb begin
    prod      = {4'b0, accum_r} * (FIELD_BITS+4)'(10) + (FIELD_BITS+4)'(c - 8'd48);
    v         = neg_r ? -$signed({8'b0, accum_r}) : $signed({8'b0, accum_r});
    chars_inc = (chars_r < 3'd7) ? chars_r + 3'd1 : chars_r;
    is_digit  = !at_end && (c inside {[8'd48:8'd57]});
    is_sign   = (c == 8'd43) || (c == 8'd45);
    case (chars_r)
      3'd1:    vscaled = v * PW'(100);
      3'd2:    vscaled = v * PW'(10);
      default: vscaled = v;
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    accum_nxt  = accum_r;
    neg_nxt    = neg_r;
    sgn_nxt    = sgn_r;
    seen_nxt   = seen_r;
    chars_nxt  = chars_r;
    tzneg_nxt  = tzneg_r;
    failed_nxt = failed_r;
    ign_nxt    = ign_r;
    parts_nxt  = parts_r;
    if (feed_en && !failed_r && !ign_r) begin
      if (is_digit) begin
        accum_nxt = (prod > {4'b0, MAG_MAX}) ? MAG_MAX : prod[FIELD_BITS-1:0];
        seen_nxt  = 1'b1;
        chars_nxt = chars_inc;
      end else if (!seen_r) begin
        if (!at_end && !sgn_r && (c inside {8'd32, [8'd9:8'd13]})) begin
          chars_nxt = chars_inc;
        end else if (!at_end && !sgn_r && is_sign) begin
          sgn_nxt   = 1'b1;
          neg_nxt   = (c == 8'd45);
          chars_nxt = chars_inc;
        end else begin
          failed_nxt = 1'b1;
        end
      end else if (phase_r > PH_TZMIN) begin
        failed_nxt = 1'b1;
      end else begin
        for (int i = 0; i < NUM_PARTS; i++) begin
          if (phase_r == 4'(i)) parts_nxt[i] = v;
        end
        // start a fresh field unless a branch below stops parsing
        accum_nxt = '0;
        neg_nxt   = 1'b0;
        sgn_nxt   = 1'b0;
        chars_nxt = 3'd0;
        seen_nxt  = 1'b0;
        case (phase_r)
          PH_YEAR, PH_MONTH, PH_HOUR, PH_MINUTE, PH_TZHOUR: begin
            if (at_end) failed_nxt = 1'b1;
            else phase_nxt = phase_r + 4'd1;
          end
          PH_DAY: begin
            if (at_end) ign_nxt = 1'b1;
            else if (c == 8'd84) phase_nxt = PH_HOUR;
            else failed_nxt = 1'b1;
          end
          PH_SECOND, PH_FRAC: begin
            if (phase_r == PH_FRAC) parts_nxt[6] = vscaled;
            if (phase_r == PH_FRAC && chars_r > 3'(FRACTION_DIGITS)) begin
              failed_nxt = 1'b1;
            end else if (phase_r == PH_SECOND && !at_end && c == 8'd46) begin
              phase_nxt = PH_FRAC;
            end else if (at_end || c == 8'd90) begin
              ign_nxt = 1'b1;
            end else if (is_sign) begin
              phase_nxt = PH_TZHOUR;
              tzneg_nxt = (c == 8'd45);
              sgn_nxt   = 1'b1;
              neg_nxt   = (c == 8'd45);
              chars_nxt = 3'd1;
            end else begin
              failed_nxt = 1'b1;
            end
          end
          default: ign_nxt = 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      phase_r  <= PH_YEAR;
      accum_r  <= '0;
      neg_r    <= 1'b0;
      sgn_r    <= 1'b0;
      seen_r   <= 1'b0;
      chars_r  <= 3'd0;
      tzneg_r  <= 1'b0;
      failed_r <= 1'b0;
      ign_r    <= 1'b0;
      for (int i = 0; i < NUM_PARTS; i++) parts_r[i] <= '0;
    end else begin
      phase_r  <= phase_nxt;
      accum_r  <= accum_nxt;
      neg_r    <= neg_nxt;
      sgn_r    <= sgn_nxt;
      seen_r   <= seen_nxt;
      chars_r  <= chars_nxt;
      tzneg_r  <= tzneg_nxt;
      failed_r <= failed_nxt;
      ign_r    <= ign_nxt;
      parts_r  <= parts_nxt;
    end
  end

  assign flags = '{failed: failed_r, ignore_rest: ign_r, tz_negative: tzneg_r};
  assign parts = parts_r;
endmodule

// File: hdl/isots_cal.sv
// Calendar sequencer: range check, offset, and one-day-per-cycle UTC stepping.
module isots_cal import isots_pkg::*; #(
  parameter int FIELD_BITS = FIELD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         ack,
  input  parse_flags_t                 flags,
  input  logic signed [FIELD_BITS+7:0] parts [NUM_PARTS],
  output logic                         done,
  output result_t                      res
);
  localparam int PW = FIELD_BITS + 8;

  cal_state_t           state_r, state_nxt;
  logic [1:0]           status_r, status_nxt;
  logic [13:0]          wy_r, wy_nxt, rem_r, rem_nxt;
  logic [3:0]           wmo_r, wmo_nxt;
  logic [4:0]           wd_r, wd_nxt;
  logic signed [PW-1:0] wt_r, wt_nxt;
  logic [4:0]           ml, ml_in, ml_prev;
  logic [8:0]           rem_up, rem_dn;
  logic                 bad;
  logic [10:0]          r;
  logic [22:0]          hq;
  logic [4:0]           hr;
  logic [10:0]          hr60;

  always_comb begin
    rem_up  = (rem_r[8:0] == 9'(LEAP_CYCLE - 1)) ? 9'd0 : rem_r[8:0] + 9'd1;
    rem_dn  = (rem_r[8:0] == 9'd0) ? 9'(LEAP_CYCLE - 1) : rem_r[8:0] - 9'd1;
    ml      = month_len(wmo_r, leap_of(rem_r[8:0]));
    ml_prev = month_len(wmo_r - 4'd1, leap_of(rem_r[8:0]));
    ml_in   = month_len(parts[1][3:0], leap_of(rem_r[8:0]));
    bad = parts[1] < PW'(1) || parts[1] > PW'(12) ||
          parts[2] < PW'(1) || parts[2] > PW'(31) || parts[2][4:0] > ml_in ||
          parts[3] < PW'(0) || parts[3] > PW'(23) ||
          parts[4] < PW'(0) || parts[4] > PW'(59) ||
          parts[5] < PW'(0) || parts[5] > PW'(59) ||
          parts[6] < PW'(0) || parts[6] > PW'(MS_MAX);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      C_IDLE: begin
        if (start) begin
          if (flags.failed || !flags.ignore_rest ||
              parts[0] < PW'(1) || parts[0] > PW'(YEAR_MAX)) state_nxt = C_DONE;
          else state_nxt = C_MOD;
        end
      end
      C_MOD:   if (rem_r < 14'(LEAP_CYCLE)) state_nxt = C_CHECK;
      C_CHECK: state_nxt = bad ? C_DONE : C_OFF;
      C_OFF:   state_nxt = C_T;
      C_T:     state_nxt = C_STEP;
      C_STEP: begin
        if (wt_r >= PW'(MIN_PER_DAY)) begin
          if (wd_r >= ml && wmo_r == 4'd12 && wy_r == 14'(YEAR_MAX)) state_nxt = C_DONE;
        end else if (wt_r < PW'(0)) begin
          if (wd_r == 5'd1 && wmo_r == 4'd1 && wy_r == 14'd1) state_nxt = C_DONE;
        end else begin
          state_nxt = C_DONE;
        end
      end
      C_DONE:  if (ack) state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    status_nxt = status_r;
    wy_nxt     = wy_r;
    rem_nxt    = rem_r;
    wmo_nxt    = wmo_r;
    wd_nxt     = wd_r;
    wt_nxt     = wt_r;
    case (state_r)
      C_IDLE: begin
        status_nxt = ST_OK;
        wy_nxt     = parts[0][13:0];
        rem_nxt    = parts[0][13:0];
        if (flags.failed || !flags.ignore_rest) status_nxt = ST_SYNTAX;
        else if (parts[0] < PW'(1) || parts[0] > PW'(YEAR_MAX)) status_nxt = ST_RANGE;
      end
      C_MOD: if (rem_r >= 14'(LEAP_CYCLE)) rem_nxt = rem_r - 14'(LEAP_CYCLE);
      C_CHECK: begin
        wmo_nxt = parts[1][3:0];
        wd_nxt  = parts[2][4:0];
        if (bad) status_nxt = ST_RANGE;
      end
      C_OFF: begin
        wt_nxt = flags.tz_negative ? parts[7] * PW'(MIN_PER_HOUR) - parts[8]
                                   : parts[7] * PW'(MIN_PER_HOUR) + parts[8];
      end
      C_T: wt_nxt = parts[3] * PW'(MIN_PER_HOUR) + parts[4] - wt_r;
      C_STEP: begin
        if (wt_r >= PW'(MIN_PER_DAY)) begin
          wt_nxt = wt_r - PW'(MIN_PER_DAY);
          if (wd_r >= ml) begin
            wd_nxt = 5'd1;
            if (wmo_r == 4'd12) begin
              wmo_nxt = 4'd1;
              wy_nxt  = wy_r + 14'd1;
              rem_nxt = {5'b0, rem_up};
              if (wy_r == 14'(YEAR_MAX)) status_nxt = ST_UTC;
            end else begin
              wmo_nxt = wmo_r + 4'd1;
            end
          end else begin
            wd_nxt = wd_r + 5'd1;
          end
        end else if (wt_r < PW'(0)) begin
          wt_nxt = wt_r + PW'(MIN_PER_DAY);
          if (wd_r == 5'd1) begin
            if (wmo_r == 4'd1) begin
              wmo_nxt = 4'd12;
              wd_nxt  = MONTH_DAYS[12];
              wy_nxt  = wy_r - 14'd1;
              rem_nxt = {5'b0, rem_dn};
              if (wy_r == 14'd1) status_nxt = ST_UTC;
            end else begin
              wmo_nxt = wmo_r - 4'd1;
              wd_nxt  = ml_prev;
            end
          end else begin
            wd_nxt = wd_r - 5'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= C_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    wy_r     <= wy_nxt;
    rem_r    <= rem_nxt;
    wmo_r    <= wmo_nxt;
    wd_r     <= wd_nxt;
    wt_r     <= wt_nxt;
  end

  // hour = r / 60 by reciprocal, exact for r below 1440
  always_comb begin
    r    = wt_r[10:0];
    hq   = {12'b0, r} * 23'd2185;
    hr   = hq[21:17];
    hr60 = 11'(hr) * 11'd60;
    done = (state_r == C_DONE);
    res  = '0;
    res.status = status_r;
    if (status_r == ST_OK) begin
      res.year        = wy_r;
      res.month       = wmo_r;
      res.day         = wd_r;
      res.hour        = hr;
      res.minute      = 6'(r - hr60);
      res.second      = parts[5][5:0];
      res.millisecond = parts[6][9:0];
    end
  end
endmodule

// File: hdl/isots_checker.sv
// Port-level checker for the timestamp parser, bound to the top level.
`include "iso8601_timestamp_parser_macros.svh"
module isots_checker import isots_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_text_char,
  input logic        in_is_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [13:0] out_year,
  input logic [3:0]  out_month,
  input logic [4:0]  out_day,
  input logic [4:0]  out_hour,
  input logic [5:0]  out_minute,
  input logic [5:0]  out_second,
  input logic [9:0]  out_millisecond
);
  `ISOTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_year) && $stable(out_status))
  `ISOTS_ASSERT_NOW(a_err_zero, out_valid && out_status != ST_OK,
    out_year == 14'd0 && out_month == 4'd0 && out_day == 5'd0)
  `ISOTS_ASSERT_NOW(a_ok_range, out_valid && out_status == ST_OK,
    out_year >= 14'd1 && out_month >= 4'd1 && out_month <= 4'd12 && out_day >= 5'd1 &&
    out_hour <= 5'd23 && out_minute <= 6'd59 && out_second <= 6'd59 &&
    out_millisecond <= 10'd999)
  `ISOTS_ASSERT_NEXT(a_busy_after_last, in_valid && in_ready && in_is_last, !in_ready)
endmodule

bind iso8601_timestamp_parser isots_checker u_isots_checker (.*);
